### hdl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL.
// No dependencies; define SYNTH to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define SCLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent in the next cycle.
`define SCLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SCLT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SCLT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/sclt_pkg.sv
// Shared types, character codes and helper functions for the tokenizer.
// No dependencies.
package sclt_pkg;

  localparam int MAX_RES = 5;
  localparam int CNT_W   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [3:0] {
    M_IDLE     = 4'd0,
    M_COMMENT  = 4'd1,
    M_SQ       = 4'd2,
    M_DQ       = 4'd3,
    M_DQ_ESC   = 4'd4,
    M_WORD     = 4'd5,
    M_WORD_ESC = 4'd6
  } mode_t;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_PIPE = 2'd1,
    OP_GT   = 2'd2,
    OP_AMP  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_CHAR    = 2'd0,
    K_END     = 2'd1,
    K_ABANDON = 2'd2,
    K_LINE    = 2'd3
  } kind_t;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } res_t;

  // All results caused by one input byte, in order.
  typedef struct packed {
    res_t [MAX_RES-1:0] res;
    logic [CNT_W-1:0]   cnt;
  } bundle_t;

  function automatic op_t op_code(logic [7:0] c);
    op_t r;
    unique case (c)
      CH_PIPE: r = OP_PIPE;
      CH_GT:   r = OP_GT;
      CH_AMP:  r = OP_AMP;
      default: r = OP_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] op_char(op_t op);
    logic [7:0] r;
    unique case (op)
      OP_PIPE: r = CH_PIPE;
      OP_GT:   r = CH_GT;
      OP_AMP:  r = CH_AMP;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  // Append one result; drop it once the bundle is full.
  function automatic bundle_t bun_put(bundle_t b, kind_t k, logic [7:0] ch);
    bundle_t r;
    r = b;
    if (r.cnt < CNT_W'(MAX_RES)) begin
      r.res[r.cnt].kind = k;
      r.res[r.cnt].ch   = (k == K_CHAR) ? ch : 8'h00;
      r.cnt             = r.cnt + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

### hdl/sclt_if.sv
// Valid/ready channel interfaces for the tokenizer input and result streams.
// Depends on sclt_pkg for the result kind type.
interface sclt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;
  modport source (output valid, output char_in, output line_end, input ready);
  modport sink   (input valid, input char_in, input line_end, output ready);
endinterface

interface sclt_out_if;
  logic            valid;
  logic            ready;
  sclt_pkg::kind_t kind;
  logic [7:0]      char_out;
  logic            last;
  modport source (output valid, output kind, output char_out, output last, input ready);
  modport sink   (input valid, input kind, input char_out, input last, output ready);
endinterface

### hdl/sclt_front.sv
// Front end: accepts one byte per cycle unless q_full, steps the lexer state
// and builds the bundle of results for it. Depends on sclt_pkg and sclt_if.
module sclt_front (
  input  logic              clk,
  input  logic              rst_n,
  sclt_in_if.sink           in_chan,
  input  logic              q_full,
  output logic              q_push,
  output sclt_pkg::bundle_t q_bundle
);

  sclt_pkg::mode_t mode_r, mode_nxt;
  sclt_pkg::op_t   held_r, held_nxt;
  logic            ws_r, ws_nxt;
  logic            accept;

  always_comb begin
    logic [7:0]        c;
    logic [7:0]        oc;
    sclt_pkg::op_t     cop;
    sclt_pkg::bundle_t b;
    logic              do_idle;
    logic              do_word;
    c        = in_chan.char_in;
    cop      = sclt_pkg::op_code(c);
    mode_nxt = mode_r;
    held_nxt = held_r;
    ws_nxt   = ws_r;
    b        = '0;
    do_idle  = 1'b0;
    do_word  = 1'b0;
    oc       = sclt_pkg::op_char(held_r);

    if (held_r != sclt_pkg::OP_NONE) begin
      // Resolve the held operator with this byte as lookahead.
      held_nxt = sclt_pkg::OP_NONE;
      mode_nxt = sclt_pkg::M_IDLE;
      b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, oc);
      if (c == oc) begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, oc);
        b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
      end else begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
        do_idle = 1'b1;
      end
    end else begin
      unique case (mode_r)
        sclt_pkg::M_COMMENT: ;
        sclt_pkg::M_SQ: begin
          if (c == sclt_pkg::CH_SQ) begin
            b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
            mode_nxt = sclt_pkg::M_IDLE;
          end else begin
            b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
          end
        end
        sclt_pkg::M_DQ: begin
          if (c == sclt_pkg::CH_DQ) begin
            b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
            mode_nxt = sclt_pkg::M_IDLE;
          end else if (c == sclt_pkg::CH_BSL) begin
            mode_nxt = sclt_pkg::M_DQ_ESC;
          end else begin
            b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
          end
        end
        sclt_pkg::M_DQ_ESC: begin
          mode_nxt = sclt_pkg::M_DQ;
          unique case (c) inside
            sclt_pkg::CH_LF: ;
            sclt_pkg::CH_BSL, sclt_pkg::CH_DQ: b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
            sclt_pkg::CH_N: b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, sclt_pkg::CH_LF);
            sclt_pkg::CH_T: b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, sclt_pkg::CH_TAB);
            sclt_pkg::CH_R: b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, sclt_pkg::CH_CR);
            default: begin
              b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, sclt_pkg::CH_BSL);
              b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
            end
          endcase
        end
        sclt_pkg::M_WORD: do_word = 1'b1;
        sclt_pkg::M_WORD_ESC: begin
          mode_nxt = sclt_pkg::M_WORD;
          if (c == sclt_pkg::CH_LF) begin
          end else if (cop != sclt_pkg::OP_NONE) begin
            if (ws_r) b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
            ws_nxt   = 1'b0;
            mode_nxt = sclt_pkg::M_IDLE;
            held_nxt = cop;
          end else begin
            b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
            ws_nxt = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase
    end

    if (do_idle) begin
      mode_nxt = sclt_pkg::M_IDLE;
      if (c == sclt_pkg::CH_SP || c == sclt_pkg::CH_TAB) begin
      end else if (c == sclt_pkg::CH_HASH) begin
        mode_nxt = sclt_pkg::M_COMMENT;
      end else if (cop != sclt_pkg::OP_NONE) begin
        held_nxt = cop;
      end else if (c == sclt_pkg::CH_SQ) begin
        mode_nxt = sclt_pkg::M_SQ;
      end else if (c == sclt_pkg::CH_DQ) begin
        mode_nxt = sclt_pkg::M_DQ;
      end else begin
        mode_nxt = sclt_pkg::M_WORD;
        ws_nxt   = 1'b0;
        do_word  = 1'b1;
      end
    end

    if (do_word) begin
      if (c == sclt_pkg::CH_SP || c == sclt_pkg::CH_TAB) begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
        ws_nxt   = 1'b0;
        mode_nxt = sclt_pkg::M_IDLE;
      end else if (c == sclt_pkg::CH_BSL) begin
        mode_nxt = sclt_pkg::M_WORD_ESC;
      end else if (c == sclt_pkg::CH_DQ || c == sclt_pkg::CH_SQ) begin
        // drop quotes inside a bare word
      end else if (cop != sclt_pkg::OP_NONE) begin
        if (ws_nxt) b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
        ws_nxt   = 1'b0;
        mode_nxt = sclt_pkg::M_IDLE;
        held_nxt = cop;
      end else begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, c);
        ws_nxt = 1'b1;
      end
    end

    if (in_chan.line_end) begin
      // Flush the held operator, close or abandon the open token, mark line end.
      if (held_nxt != sclt_pkg::OP_NONE) begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_CHAR, sclt_pkg::op_char(held_nxt));
        b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
      end
      if (mode_nxt == sclt_pkg::M_SQ || mode_nxt == sclt_pkg::M_DQ ||
          mode_nxt == sclt_pkg::M_DQ_ESC) begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_ABANDON, 8'h00);
      end else if (mode_nxt == sclt_pkg::M_WORD || mode_nxt == sclt_pkg::M_WORD_ESC) begin
        b = sclt_pkg::bun_put(b, sclt_pkg::K_END, 8'h00);
      end
      b = sclt_pkg::bun_put(b, sclt_pkg::K_LINE, 8'h00);
      mode_nxt = sclt_pkg::M_IDLE;
      held_nxt = sclt_pkg::OP_NONE;
      ws_nxt   = 1'b0;
    end

    q_bundle = b;
  end

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && !q_full;
  assign q_push        = accept && (q_bundle.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sclt_pkg::M_IDLE;
      held_r <= sclt_pkg::OP_NONE;
      ws_r   <= 1'b0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      ws_r   <= ws_nxt;
    end
  end

endmodule

### hdl/sclt_fifo.sv
// Short bundle queue between front and back ends.
// Depends on sclt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sclt_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sclt_pkg::bundle_t wr_bundle,
  output logic              full,
  input  logic              pop,
  output logic              rd_valid,
  output sclt_pkg::bundle_t rd_bundle
);

  sclt_pkg::bundle_t              mem_r [sclt_pkg::Q_DEPTH];
  logic [sclt_pkg::Q_AW-1:0]      wr_ptr_r;
  logic [sclt_pkg::Q_AW-1:0]      rd_ptr_r;
  logic [sclt_pkg::Q_AW:0]        count_r;

  assign full      = (count_r == (sclt_pkg::Q_AW+1)'(sclt_pkg::Q_DEPTH));
  assign rd_valid  = (count_r != '0);
  assign rd_bundle = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + sclt_pkg::Q_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + sclt_pkg::Q_AW'(1);
      if (push && !pop)      count_r <= count_r + (sclt_pkg::Q_AW+1)'(1);
      else if (pop && !push) count_r <= count_r - (sclt_pkg::Q_AW+1)'(1);
    end
  end

  `SCLT_ASSERT_IMP(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `SCLT_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, rd_valid, "pop from empty queue")

endmodule

### hdl/sclt_back.sv
// Back end: unpacks one bundle at a time into single result transactions.
// Depends on sclt_pkg, sclt_if and assert_macros.svh.
`include "assert_macros.svh"
module sclt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sclt_pkg::bundle_t q_bundle,
  output logic              q_pop,
  sclt_out_if.source        out_chan
);

  sclt_pkg::bundle_t           bun_r;
  logic [sclt_pkg::CNT_W-1:0]  idx_r;
  logic                        have_r;
  logic                        last_now;
  logic                        load;

  assign last_now = (idx_r == bun_r.cnt - sclt_pkg::CNT_W'(1));
  assign load     = q_valid && (!have_r || (out_chan.ready && last_now));
  assign q_pop    = load;

  assign out_chan.valid    = have_r;
  assign out_chan.kind     = bun_r.res[idx_r].kind;
  assign out_chan.char_out = bun_r.res[idx_r].ch;
  assign out_chan.last     = last_now;

  always_ff @(posedge clk) begin
    if (load) bun_r <= q_bundle;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      have_r <= 1'b1;
      idx_r  <= '0;
    end else if (have_r && out_chan.ready) begin
      if (last_now) have_r <= 1'b0;
      else          idx_r  <= idx_r + sclt_pkg::CNT_W'(1);
    end
  end

  `SCLT_ASSERT_IMP(a_bundle_nonempty, clk, rst_n, have_r, bun_r.cnt != '0, "empty bundle held")
  `SCLT_ASSERT_NXT(a_burst_continues, clk, rst_n, have_r && out_chan.ready && !last_now, have_r, "burst cut short")

endmodule

### hdl/shell_command_line_tokenizer.sv
// Command-line tokenizer top level: front end, bundle queue, back end.
// Each bundle is queued, then loaded into the back end's output register.
// Throughput: one byte per cycle in unless the queue is full; results leave
// one per cycle while the sink is ready, bounded by the single result port.
// Reset (rst_n low, synchronous): lexer idle, queue and output stage empty.
module shell_command_line_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  sclt_in_if.sink     in_chan,
  sclt_out_if.source  out_chan
);

  // Front to queue: one bundle per byte that produces any result.
  logic              q_push;
  logic              q_full;
  sclt_pkg::bundle_t q_wr_bundle;

  // Queue to back: the oldest bundle waiting for the output port.
  logic              q_pop;
  logic              q_valid;
  sclt_pkg::bundle_t q_rd_bundle;

  // Classify each byte and step the lexer state in the cycle it arrives.
  sclt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_bundle (q_wr_bundle)
  );

  // Absorb bursts so the input keeps flowing while results drain.
  sclt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_bundle (q_wr_bundle),
    .full      (q_full),
    .pop       (q_pop),
    .rd_valid  (q_valid),
    .rd_bundle (q_rd_bundle)
  );

  // Emit each bundle one result per cycle while ready, flag the last one.
  sclt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_bundle (q_rd_bundle),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
